@@ hw/rtl/ecl_pkg.sv @@
// ----------------------------------------------------------------------------
// ecl_pkg: shared constants and types of the equivalence class lister
// Element and link storage sizes, null link code, walker result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ecl_pkg;

	localparam int ELEMENTS      = 32;
	localparam int PAIR_CAPACITY = 64;
	localparam int EDGE_SLOTS    = 2 * PAIR_CAPACITY;

	localparam int IDX_W   = 5;                        // element index field width
	localparam int CNT_W   = 6;                        // element_count register width
	localparam int EADDR_W = $clog2(EDGE_SLOTS);       // link memory address
	localparam int EPTR_W  = $clog2(EDGE_SLOTS + 1);   // link pointer incl. null
	localparam int LINK_W  = IDX_W + EPTR_W;           // neighbor plus next pointer

	localparam logic [EPTR_W-1:0] NO_EDGE     = EPTR_W'(EDGE_SLOTS);
	localparam logic [EPTR_W-1:0] EDGE_LIMIT  = EPTR_W'(EDGE_SLOTS - 2);
	localparam logic [CNT_W-1:0]  ELEM_CNT    = CNT_W'(ELEMENTS);
	localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(32);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] member;
		logic             starts_class;
		logic [IDX_W-1:0] class_leader;
		logic             dropped_pairs;
		logic             last;
	} emit_t;

endpackage

`default_nettype wire

@@ hw/rtl/ecl_ram.sv @@
// ----------------------------------------------------------------------------
// ecl_ram: generic single-write, single-read RAM
// One write port, one read port with enabled, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ecl_walker.sv @@
// ----------------------------------------------------------------------------
// ecl_walker: link loader and class walk sequencer
// Builds per-element neighbor lists in link RAM, then walks them with a stack.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_walker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	input  wire logic                      opcode,
	input  wire logic [ecl_pkg::IDX_W-1:0] first_element,
	input  wire logic [ecl_pkg::IDX_W-1:0] second_element,
	output logic                           item_stall,
	input  wire logic [ecl_pkg::CNT_W-1:0] count,      // effective element count
	input  wire logic                      emit_ok,    // output slot can take a result
	output ecl_pkg::emit_t                 emit
);

	typedef enum logic [2:0] {IDLE, LOAD2, SCAN, WALK, READ} state_t;

	state_t                       state_q;
	logic [ecl_pkg::EPTR_W-1:0]   head_q [ecl_pkg::ELEMENTS];
	logic [ecl_pkg::ELEMENTS-1:0] unlisted_q;
	logic [ecl_pkg::IDX_W-1:0]    stack_q [ecl_pkg::ELEMENTS];
	logic [ecl_pkg::CNT_W-1:0]    depth_q;
	logic [ecl_pkg::EPTR_W-1:0]   edge_cnt_q;
	logic                         drop_q;
	logic [ecl_pkg::IDX_W-1:0]    pa_q, pb_q;
	logic [ecl_pkg::CNT_W-1:0]    scan_q;
	logic [ecl_pkg::IDX_W-1:0]    leader_q;
	logic [ecl_pkg::EPTR_W-1:0]   e_q;
	logic [ecl_pkg::CNT_W-1:0]    emit_cnt_q;

	logic                         accept;
	logic                         pair_bad;
	logic [ecl_pkg::IDX_W-1:0]    head_addr;
	logic [ecl_pkg::EPTR_W-1:0]   head_rd;
	logic [ecl_pkg::IDX_W-1:0]    stack_top;
	logic [ecl_pkg::CNT_W-1:0]    depth_dec;
	logic                         ram_we, ram_re;
	logic [ecl_pkg::LINK_W-1:0]   ram_wdata, ram_rdata;
	logic [ecl_pkg::IDX_W-1:0]    nb;
	logic [ecl_pkg::EPTR_W-1:0]   nb_next;
	logic                         scan_done, scan_hit, nb_hit;
	logic [ecl_pkg::IDX_W-1:0]    scan_idx;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != IDLE);
	assign pair_bad   = ({1'b0, first_element} >= count) || ({1'b0, second_element} >= count)
	                    || (edge_cnt_q > ecl_pkg::EDGE_LIMIT);

	assign depth_dec = depth_q - 1'b1;
	assign stack_top = stack_q[depth_dec[ecl_pkg::IDX_W-1:0]];
	assign scan_idx  = scan_q[ecl_pkg::IDX_W-1:0];

	always_comb begin
		unique case (state_q)
			LOAD2:   head_addr = pb_q;
			SCAN:    head_addr = scan_idx;
			WALK:    head_addr = stack_top;
			default: head_addr = first_element;
		endcase
	end
	assign head_rd = head_q[head_addr];

	assign {nb, nb_next} = ram_rdata;
	assign scan_done = (scan_q >= count);
	assign scan_hit  = !scan_done && unlisted_q[scan_idx];
	assign nb_hit    = ({1'b0, nb} < count) && unlisted_q[nb];

	// link writes: first half of a pair at accept, second half in LOAD2
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {second_element, head_rd};
		if (state_q == IDLE && accept && opcode == ecl_pkg::OP_LOAD && !pair_bad) begin
			ram_we = 1'b1;
		end else if (state_q == LOAD2) begin
			ram_we    = 1'b1;
			ram_wdata = {pa_q, head_rd};
		end
	end
	assign ram_re = (state_q == WALK) && (e_q < ecl_pkg::NO_EDGE);

	ecl_ram #(
		.WIDTH(ecl_pkg::LINK_W),
		.DEPTH(ecl_pkg::EDGE_SLOTS)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (edge_cnt_q[ecl_pkg::EADDR_W-1:0]),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (e_q[ecl_pkg::EADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	always_comb begin
		emit               = '0;
		emit.dropped_pairs = drop_q;
		emit.last          = (emit_cnt_q == count - 1'b1);
		if (state_q == SCAN) begin
			emit.valid        = scan_hit && emit_ok;
			emit.member       = scan_idx;
			emit.starts_class = 1'b1;
			emit.class_leader = scan_idx;
		end else if (state_q == READ) begin
			emit.valid        = nb_hit && emit_ok;
			emit.member       = nb;
			emit.class_leader = leader_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == READ && nb_hit && emit_ok && depth_q < ecl_pkg::ELEM_CNT) begin
			stack_q[depth_q[ecl_pkg::IDX_W-1:0]] <= nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			head_q     <= '{default: ecl_pkg::NO_EDGE};
			unlisted_q <= '1;
			depth_q    <= '0;
			edge_cnt_q <= '0;
			drop_q     <= 1'b0;
			pa_q       <= '0;
			pb_q       <= '0;
			scan_q     <= '0;
			leader_q   <= '0;
			e_q        <= ecl_pkg::NO_EDGE;
			emit_cnt_q <= '0;
		end else begin
			if (emit.valid) begin
				emit_cnt_q <= emit_cnt_q + 1'b1;
			end
			unique case (state_q)
				IDLE: begin
					if (accept && opcode == ecl_pkg::OP_END) begin
						scan_q     <= '0;
						emit_cnt_q <= '0;
						state_q    <= SCAN;
					end else if (accept && pair_bad) begin
						drop_q <= 1'b1;
					end else if (accept) begin
						head_q[first_element] <= edge_cnt_q;
						edge_cnt_q            <= edge_cnt_q + 1'b1;
						pa_q                  <= first_element;
						pb_q                  <= second_element;
						state_q               <= LOAD2;
					end
				end
				LOAD2: begin
					head_q[pb_q] <= edge_cnt_q;
					edge_cnt_q   <= edge_cnt_q + 1'b1;
					state_q      <= IDLE;
				end
				SCAN: begin
					if (scan_done) begin
						// listing complete: back to the empty-graph state
						head_q     <= '{default: ecl_pkg::NO_EDGE};
						unlisted_q <= '1;
						depth_q    <= '0;
						edge_cnt_q <= '0;
						drop_q     <= 1'b0;
						state_q    <= IDLE;
					end else if (!unlisted_q[scan_idx]) begin
						scan_q <= scan_q + 1'b1;
					end else if (emit_ok) begin
						unlisted_q[scan_idx] <= 1'b0;
						leader_q             <= scan_idx;
						e_q                  <= head_rd;
						depth_q              <= '0;
						state_q              <= WALK;
					end
				end
				WALK: begin
					if (e_q < ecl_pkg::NO_EDGE) begin
						state_q <= READ;
					end else if (depth_q == '0) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= SCAN;
					end else begin
						depth_q <= depth_dec;
						e_q     <= head_rd;   // list of the popped element
					end
				end
				READ: begin
					if (!nb_hit) begin
						e_q     <= nb_next;
						state_q <= WALK;
					end else if (emit_ok) begin
						unlisted_q[nb] <= 1'b0;
						if (depth_q < ecl_pkg::ELEM_CNT) begin
							depth_q <= depth_q + 1'b1;
						end
						e_q     <= nb_next;
						state_q <= WALK;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> emit_ok)
		else $error("result issued while output slot busy");
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= ecl_pkg::ELEM_CNT)
		else $error("walk stack overflow");
	a_edge_max: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q <= ecl_pkg::NO_EDGE)
		else $error("link count beyond capacity");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN && scan_done) |=> (edge_cnt_q == '0 && unlisted_q == '1 && !drop_q))
		else $error("state not cleared after listing");
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == READ) |-> (e_q < ecl_pkg::NO_EDGE))
		else $error("link read through null pointer");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/equivalence_class_lister.sv @@
// ----------------------------------------------------------------------------
// equivalence_class_lister: lists elements grouped by equivalence class
// Loads pairs into neighbor lists, then emits every element once per class.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  item     | item_valid / item_stall | opcode, first_element, second_element
//  result   | result_valid / result_stall | member, starts_class, class_leader,
//           |                         |   dropped_pairs, last
//  config   | cfg_valid / cfg_ready   | element_count
//
//  A pair load makes two link RAM writes, one per direction.
//  An end item scans the elements and walks each class's neighbor lists
//  with a stack; the link RAM read in the walk loop is registered.
//  The block stalls its item channel from transfer until its work is done.
//  A stalled result holds in the output register and the walk waits on it.
//  Reset and the end of each listing return to empty lists; element_count
//  keeps its value (32 after reset).
// ----------------------------------------------------------------------------
`default_nettype none

module equivalence_class_lister (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [ecl_pkg::CNT_W-1:0] element_count,
	// items
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire logic                      opcode,
	input  wire logic [ecl_pkg::IDX_W-1:0] first_element,
	input  wire logic [ecl_pkg::IDX_W-1:0] second_element,
	// results
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [ecl_pkg::IDX_W-1:0]      member,
	output logic                           starts_class,
	output logic [ecl_pkg::IDX_W-1:0]      class_leader,
	output logic                           dropped_pairs,
	output logic                           last
);

	logic [ecl_pkg::CNT_W-1:0] count_q;     // element_count register
	logic [ecl_pkg::CNT_W-1:0] count_eff;   // saturated to ELEMENTS
	logic                      emit_ok;
	ecl_pkg::emit_t            emit;
	ecl_pkg::emit_t            res_q;       // output register

	// the user must issue writes only while idle (not enforced here); the port never pushes back
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ecl_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= element_count;
		end
	end

	assign count_eff = (count_q > ecl_pkg::ELEM_CNT) ? ecl_pkg::ELEM_CNT : count_q;

	// slot is free when empty or when its result transfers this cycle
	assign emit_ok = !res_q.valid || !result_stall;

	ecl_walker u_walker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.opcode         (opcode),
		.first_element  (first_element),
		.second_element (second_element),
		.item_stall     (item_stall),
		.count          (count_eff),
		.emit_ok        (emit_ok),
		.emit           (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (emit.valid) begin
			res_q <= emit;
		end else if (!result_stall) begin
			res_q.valid <= 1'b0;
		end
	end

	assign result_valid  = res_q.valid;
	assign member        = res_q.member;
	assign starts_class  = res_q.starts_class;
	assign class_leader  = res_q.class_leader;
	assign dropped_pairs = res_q.dropped_pairs;
	assign last          = res_q.last;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.valid && result_stall) |=> (res_q.valid && $stable(res_q)))
		else $error("pending result overwritten");
	a_start_leader: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.valid && res_q.starts_class) |-> (res_q.member == res_q.class_leader))
		else $error("class start is not its own leader");
	a_leader_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid |-> (res_q.class_leader <= res_q.member))
		else $error("leader above member");
`endif

endmodule

`default_nettype wire
